[hw/rtl/ccrc_pkg.sv]
// Shared types and constants for the config record checker.
package ccrc_pkg;

    localparam int unsigned POS_W    = 19;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned FIELDS   = 6;

    localparam logic [POS_W-1:0] HDR_BYTES = 19'd24;
    localparam logic [POS_W-1:0] POS_MAX   = 19'h7FFFF;

    // header byte positions
    localparam logic [4:0] HP_DIALECT   = 5'd4;
    localparam logic [4:0] HP_ZERO      = 5'd5;
    localparam logic [4:0] HP_PORT_HI   = 5'd6;
    localparam logic [4:0] HP_PORT_LO   = 5'd7;
    localparam logic [4:0] HP_LEN_FIRST = 5'd8;
    localparam logic [4:0] HP_PAD_FIRST = 5'd20;

    localparam logic [2:0] FLD_HOST = 3'd0;
    localparam logic [2:0] FLD_PATH = 3'd1;
    localparam logic [2:0] FLD_KEY  = 3'd2;
    localparam logic [2:0] FLD_NONE = 3'd6;

    localparam logic [6:0] LABEL_MAX = 7'd63;
    localparam logic [7:0] KEY_LO    = 8'd33;
    localparam logic [7:0] KEY_HI    = 8'd126;

    localparam logic [7:0] MAGIC [4] = '{8'h43, 8'h43, 8'h46, 8'h31};

    localparam logic [15:0] NAME_LIM_RST = 16'd64;
    localparam logic [15:0] KEY_LIM_RST  = 16'd128;
    localparam logic [18:0] REC_LIM_RST  = 19'd1024;

    typedef enum logic [1:0] {
        REG_NAME_LIM = 2'd0,
        REG_KEY_LIM  = 2'd1,
        REG_REC_LIM  = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        TAG_HEADER = 3'd0,
        TAG_HOST   = 3'd1,
        TAG_PATH   = 3'd2,
        TAG_KEY    = 3'd3,
        TAG_MODEL0 = 3'd4,
        TAG_MODEL1 = 3'd5,
        TAG_MODEL2 = 3'd6,
        TAG_BEYOND = 3'd7
    } t_tag;

    typedef struct packed {
        logic [15:0] port;
        logic [1:0]  dialect;
        logic        verdict;
        logic        last;
        t_tag        tag;
        logic [7:0]  echo;
    } t_result;

    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                   (c >= "0" && c <= "9");
    endfunction

endpackage

[hw/rtl/cloud_config_record_checker.sv]
// Config record checker: byte-wide CCF1 header and field validation.
// Each accepted word's result is registered (in the skid if the output is stalled).
// Throughput: one word per cycle while s_tready is high; per-byte checks use
// only held counters and the previous byte, and the field lengths are summed
// as the header arrives. A two-entry output stage (result register plus skid)
// keeps s_tready registered. Reset (i_rst_n low, synchronous) clears the record
// state and the output stage and loads the limit registers with 64, 128 and 1024.
module cloud_config_record_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // final_byte
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] echo_byte, [8] verdict, [10:9] dialect_out,
                                   // [26:11] port_out, [31:27] zero
    output logic [2:0]  m_tuser,   // [2:0] field_tag
    output logic        m_tlast,   // record_end
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // limit registers
    logic [15:0] r_name_lim;
    logic [15:0] r_key_lim;
    logic [18:0] r_rec_lim;

    // record state
    logic [ccrc_pkg::POS_W-1:0] r_pos,   n_pos;
    logic [ccrc_pkg::POS_W-1:0] r_total, n_total;
    logic [ccrc_pkg::LEN_W-1:0] r_flen [ccrc_pkg::FIELDS];
    logic [ccrc_pkg::LEN_W-1:0] n_flen [ccrc_pkg::FIELDS];
    logic [2:0]                 r_fidx,  n_fidx;
    logic [ccrc_pkg::LEN_W-1:0] r_foff,  n_foff;
    logic [6:0]                 r_lbl,   n_lbl;
    logic [7:0]                 r_prev;
    logic [7:0]                 r_len_hi, n_len_hi;
    logic [1:0]                 r_dialect, n_dialect;
    logic [15:0]                r_port,  n_port;
    logic                       r_err,   n_err;

    // output stage
    logic                r_out_vld, r_skid_vld;
    ccrc_pkg::t_result   r_out, r_skid, res;

    logic acc_in, out_take;
    logic [7:0] c;

    assign c        = s_tdata;
    assign s_tready = ~r_skid_vld;
    assign acc_in   = s_tvalid & s_tready;
    assign out_take = r_out_vld & m_tready;

    // ---------------- register port ----------------
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            ccrc_pkg::REG_NAME_LIM: prdata = {16'd0, r_name_lim};
            ccrc_pkg::REG_KEY_LIM:  prdata = {16'd0, r_key_lim};
            ccrc_pkg::REG_REC_LIM:  prdata = {13'd0, r_rec_lim};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_lim <= ccrc_pkg::NAME_LIM_RST;
            r_key_lim  <= ccrc_pkg::KEY_LIM_RST;
            r_rec_lim  <= ccrc_pkg::REC_LIM_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                ccrc_pkg::REG_NAME_LIM: r_name_lim <= pwdata[15:0];
                ccrc_pkg::REG_KEY_LIM:  r_key_lim  <= pwdata[15:0];
                ccrc_pkg::REG_REC_LIM:  r_rec_lim  <= pwdata[18:0];
                default: ;
            endcase
        end
    end

    // ---------------- field tracking ----------------
    // The current field is finished once its offset reaches its length; then
    // the next field with a nonzero length becomes current (empty ones skipped).
    logic [ccrc_pkg::LEN_W-1:0] cur_len;
    logic                       cur_done, found;
    logic [2:0]                 eff_idx;
    logic [ccrc_pkg::LEN_W-1:0] eff_off;

    always_comb begin
        cur_len = '0;
        for (int j = 0; j < ccrc_pkg::FIELDS; j++) begin
            if (r_fidx == 3'(j))
                cur_len = r_flen[j];
        end
        cur_done = (r_fidx >= ccrc_pkg::FLD_NONE) || (r_foff == cur_len);

        found   = 1'b0;
        eff_idx = ccrc_pkg::FLD_NONE;
        eff_off = '0;
        if (!cur_done) begin
            eff_idx = r_fidx;
            eff_off = r_foff;
        end else begin
            for (int j = 0; j < ccrc_pkg::FIELDS; j++) begin
                if (!found && (3'(j) > r_fidx) && (r_flen[j] != '0)) begin
                    found   = 1'b1;
                    eff_idx = 3'(j);
                end
            end
        end
    end

    // ---------------- per-byte checks ----------------
    logic [4:0]  hp, hp_off;
    logic [2:0]  len_i;
    logic [15:0] len_full, len_lim;
    logic        in_hdr, first, last_char, ok_char;
    logic [6:0]  lbl_inc;
    logic        err_now, bad;
    logic [15:0] port_full;
    ccrc_pkg::t_tag tag;

    assign in_hdr   = r_pos < ccrc_pkg::HDR_BYTES;
    assign hp       = r_pos[4:0];
    assign hp_off   = hp - ccrc_pkg::HP_LEN_FIRST;
    assign len_i    = hp_off[3:1];
    assign len_full = {r_len_hi, c};
    assign len_lim  = (len_i == ccrc_pkg::FLD_KEY) ? r_key_lim : r_name_lim;
    assign port_full = {r_port[15:8], c};
    assign first     = eff_off == '0;
    assign last_char = ({1'b0, eff_off} + 17'd1) == {1'b0, r_flen[0]};
    assign lbl_inc   = (r_lbl <= ccrc_pkg::LABEL_MAX) ? r_lbl + 7'd1 : r_lbl;

    always_comb begin
        n_total   = r_total;
        n_flen    = r_flen;
        n_fidx    = r_fidx;
        n_foff    = r_foff;
        n_lbl     = r_lbl;
        n_len_hi  = r_len_hi;
        n_dialect = r_dialect;
        n_port    = r_port;
        err_now   = 1'b0;
        ok_char   = 1'b0;
        tag       = ccrc_pkg::TAG_HEADER;

        if (in_hdr) begin
            if (hp < ccrc_pkg::HP_DIALECT) begin
                if (c != ccrc_pkg::MAGIC[hp[1:0]])
                    err_now = 1'b1;
            end else if (hp == ccrc_pkg::HP_DIALECT) begin
                n_dialect = c[1:0];
                if (c != 8'd1 && c != 8'd2)
                    err_now = 1'b1;
            end else if (hp == ccrc_pkg::HP_ZERO) begin
                if (c != 8'd0)
                    err_now = 1'b1;
            end else if (hp == ccrc_pkg::HP_PORT_HI) begin
                n_port = {c, 8'd0};
            end else if (hp == ccrc_pkg::HP_PORT_LO) begin
                n_port = port_full;
                if (port_full == 16'd0)
                    err_now = 1'b1;
            end else if (hp < ccrc_pkg::HP_PAD_FIRST) begin
                if (!hp_off[0]) begin
                    n_len_hi = c;
                end else begin
                    n_flen[len_i] = len_full;
                    n_total       = r_total + {3'd0, len_full};
                    if (len_full == 16'd0 || len_full > len_lim)
                        err_now = 1'b1;
                end
            end else begin
                if (c != 8'd0)
                    err_now = 1'b1;
            end
        end else if (eff_idx != ccrc_pkg::FLD_NONE) begin
            tag    = ccrc_pkg::t_tag'(eff_idx + 3'd1);
            n_fidx = eff_idx;
            n_foff = eff_off + 16'd1;
            if (eff_idx == ccrc_pkg::FLD_HOST) begin
                if ((first || last_char) && !ccrc_pkg::is_alnum(c))
                    err_now = 1'b1;
                if (c == ".") begin
                    if (first || !ccrc_pkg::is_alnum(r_prev))
                        err_now = 1'b1;
                    n_lbl = '0;
                end else begin
                    if (!first && r_prev == "." && !ccrc_pkg::is_alnum(c))
                        err_now = 1'b1;
                    if (!ccrc_pkg::is_alnum(c) && c != "-")
                        err_now = 1'b1;
                    n_lbl = lbl_inc;
                    if (lbl_inc > ccrc_pkg::LABEL_MAX)
                        err_now = 1'b1;
                end
            end else if (eff_idx == ccrc_pkg::FLD_KEY) begin
                if (c < ccrc_pkg::KEY_LO || c > ccrc_pkg::KEY_HI)
                    err_now = 1'b1;
            end else begin
                ok_char = ccrc_pkg::is_alnum(c) || c == "-" || c == "_" || c == "/" ||
                          c == "." || (eff_idx != ccrc_pkg::FLD_PATH && c == ":");
                if (!ok_char)
                    err_now = 1'b1;
                if (eff_idx == ccrc_pkg::FLD_PATH) begin
                    if (first && c != "/")
                        err_now = 1'b1;
                    if (!first && c == "." && r_prev == ".")
                        err_now = 1'b1;
                end
            end
        end else begin
            tag    = ccrc_pkg::TAG_BEYOND;
            n_fidx = ccrc_pkg::FLD_NONE;
        end

        n_err = r_err | err_now;
        n_pos = (r_pos == ccrc_pkg::POS_MAX) ? r_pos : r_pos + 19'd1;
    end

    assign bad = n_err || (n_pos < ccrc_pkg::HDR_BYTES) || (n_pos > r_rec_lim) ||
                 (r_total != n_pos);

    always_comb begin
        res.echo    = c;
        res.tag     = tag;
        res.last    = s_tlast;
        res.verdict = s_tlast & bad;
        res.dialect = (s_tlast && !bad) ? r_dialect : 2'd0;
        res.port    = (s_tlast && !bad) ? r_port : 16'd0;
    end

    // ---------------- record state update ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc_in && s_tlast)) begin
            r_pos     <= '0;
            r_total   <= ccrc_pkg::HDR_BYTES;
            for (int j = 0; j < ccrc_pkg::FIELDS; j++)
                r_flen[j] <= '0;
            r_fidx    <= '0;
            r_foff    <= '0;
            r_lbl     <= '0;
            r_prev    <= '0;
            r_len_hi  <= '0;
            r_dialect <= '0;
            r_port    <= '0;
            r_err     <= 1'b0;
        end else if (acc_in) begin
            r_pos     <= n_pos;
            r_total   <= n_total;
            r_flen    <= n_flen;
            r_fidx    <= n_fidx;
            r_foff    <= n_foff;
            r_lbl     <= n_lbl;
            r_prev    <= c;
            r_len_hi  <= n_len_hi;
            r_dialect <= n_dialect;
            r_port    <= n_port;
            r_err     <= n_err;
        end
    end

    // ---------------- output stage with skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || out_take) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= acc_in;
            end
        end else if (acc_in) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || out_take) begin
            if (r_skid_vld)
                r_out <= r_skid;
            else if (acc_in)
                r_out <= res;
        end else if (acc_in) begin
            r_skid <= res;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {5'd0, r_out.port, r_out.dialect, r_out.verdict, r_out.echo};
    assign m_tuser  = r_out.tag;
    assign m_tlast  = r_out.last;

endmodule

[hw/rtl/ccrc_checker.sv]
// Port-level checks on the record checker's result stream, bound to the top level.
module ccrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // verdict, dialect and port only carry information at record end
    a_mid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tlast |-> m_tdata[26:8] == 19'd0)
        else $error("verdict fields set before record end");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[8] |-> m_tdata[26:9] == 18'd0)
        else $error("dialect or port shown on a malformed record");

    // an accepted record has a sane dialect, a nonzero port, and never ends
    // on a header byte or on a byte past its declared fields
    a_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tlast && !m_tdata[8] |->
            (m_tdata[10:9] == 2'd1 || m_tdata[10:9] == 2'd2) &&
            m_tdata[26:11] != 16'd0 && m_tuser != ccrc_pkg::TAG_BEYOND &&
            m_tuser != ccrc_pkg::TAG_HEADER)
        else $error("accepted record with inconsistent result");

endmodule

bind cloud_config_record_checker ccrc_checker u_ccrc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
